// ===== design/asd_pkg.sv =====
// Shared constants and types of the axisymmetric segment distance unit.
// No dependencies; imported by the top level.
`default_nettype none
package asd_pkg;

	// Default number of fraction bits of the fixed point coordinates.
	localparam int FRAC_BITS_DEF = 16;

	// Field widths.
	localparam int COORD_W    = 32;
	localparam int RAD_W      = 31;
	localparam int REGION_W   = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_RADIUS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_RADIUS   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_HEIGHT   = 8'd3;

	// Which part of the segment holds the nearest point.
	typedef enum logic [REGION_W-1:0] {
		REGION_START = 2'd0,
		REGION_END   = 2'd1,
		REGION_INNER = 2'd2
	} region_t;

endpackage
`default_nettype wire

// ===== design/axisymmetric_segment_distance_unit.sv =====
// Top level of the axisymmetric segment distance unit: config registers,
// arithmetic stages and rows of root and divider cells. Uses asd_pkg,
// asd_sqrt_cell and asd_div_cell.
//
//   channel   dir   handshake                  payload
//   cfg       in    cfg_valid / cfg_ready      cfg_index, cfg_data
//   s_axis    in    s_axis_tvalid / tready     tdata: point x, y, z
//   m_axis    out   m_axis_tvalid / tready     tdata: distance, nearest x, y, z
//                                              tuser: region, degenerate
//
// One point is taken per clock cycle while the stages advance. The result passes
// through the capture stages, the root row, the projection stages, the divider rows,
// the distance stages and the last divider and root rows to the output register.
// All stages advance together. They hold only when the last stage carries a
// result and the output register is full and not taken, so bubbles close up
// while a result waits. Reset clears every valid bit and loads the default
// segment from (0,0) to (1,1). cfg_ready is always high; writes to an index
// beyond the four registers are dropped.
`default_nettype none
module axisymmetric_segment_distance_unit #(
	parameter int FRAC_BITS = asd_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [asd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asd_pkg::COORD_W-1:0]      cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// point_x [31:0], point_y [63:32], point_z [95:64]
	input  logic [asd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// distance [30:0], nearest_x [62:31], nearest_y [94:63],
	// nearest_z [126:95], zero [127]
	output logic [asd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// region [1:0], degenerate [2]
	output logic [asd_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import asd_pkg::*;

	// Widths of the internal arithmetic.
	localparam int RSQ_W    = 64;   // x^2 + y^2
	localparam int ROOT_W   = 32;   // radius of the point
	localparam int PT_W     = 96;   // packed x, y, z
	localparam int LEN_W    = 66;   // squared segment length
	localparam int CHUNK_W  = 22;   // split of the projection numerator
	localparam int DIV_N_W  = 101;
	localparam int DIV_D_W  = 67;
	localparam int DIV_Q_W  = 34;
	localparam int ROT_N_W  = 64;
	localparam int ROT_D_W  = 33;
	localparam int ROT_Q_W  = 35;
	localparam int DSQ_W    = 67;
	localparam int DROOT_W  = 34;
	localparam int DIVR_S_W = PT_W + ROOT_W;
	localparam int ROTX_S_W = 2 + RAD_W + COORD_W + 1;

	// ------------------------------------------------------------------
	// Configuration registers and values derived from them. The derived
	// registers follow the segment registers via dr, dz, the squares, len2
	// and den2, long before a point that arrives after a write needs them.
	// ------------------------------------------------------------------
	logic        [RAD_W-1:0]   start_radius_q, end_radius_q;
	logic signed [COORD_W-1:0] start_height_q, end_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_radius_q <= '0;
			start_height_q <= '0;
			end_radius_q   <= RAD_W'(1) << FRAC_BITS;
			end_height_q   <= COORD_W'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_RADIUS: start_radius_q <= cfg_data[RAD_W-1:0];
				REG_START_HEIGHT: start_height_q <= cfg_data;
				REG_END_RADIUS:   end_radius_q   <= cfg_data[RAD_W-1:0];
				REG_END_HEIGHT:   end_height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0]        dr_q;
	logic signed [32:0]        dz_q;
	logic        [31:0]        mag_dr_q;
	logic        [32:0]        mag_dz_q;
	logic        [63:0]        drsq_q;
	logic        [65:0]        dzsq_q;
	logic        [LEN_W-1:0]   len2_q;
	logic        [DIV_D_W-1:0] den2_q;
	logic                      degen_q;

	always_ff @(posedge clk) begin
		dr_q     <= $signed({1'b0, end_radius_q}) - $signed({1'b0, start_radius_q});
		dz_q     <= 33'(end_height_q) - 33'(start_height_q);
		mag_dr_q <= dr_q[31] ? (32'd0 - dr_q) : dr_q;
		mag_dz_q <= dz_q[32] ? (33'd0 - dz_q) : dz_q;
		drsq_q   <= dr_q * dr_q;
		dzsq_q   <= dz_q * dz_q;
		len2_q   <= LEN_W'(drsq_q) + dzsq_q;
		den2_q   <= {len2_q, 1'b0};
		degen_q  <= (dr_q == '0) && (dz_q == '0);
	end

	// ------------------------------------------------------------------
	// Global advance. The last stage moves on when it is empty or when
	// the output register is free or being taken.
	// ------------------------------------------------------------------
	logic adv;
	logic last_valid;
	logic out_valid_q;

	assign adv           = !last_valid || !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// ------------------------------------------------------------------
	// Stages 1 to 3: capture the point and form x^2 + y^2.
	// ------------------------------------------------------------------
	logic              v_s1, v_s2, v_s3;
	logic [PT_W-1:0]   pt_s1, pt_s2, pt_s3;
	logic [RSQ_W-1:0]  axsq_s2, aysq_s2, rsq_s3;
	logic [31:0]       ax_w, ay_w;

	assign ax_w = pt_s1[31] ? (32'd0 - pt_s1[31:0]) : pt_s1[31:0];
	assign ay_w = pt_s1[63] ? (32'd0 - pt_s1[63:32]) : pt_s1[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1   <= s_axis_tdata;
			pt_s2   <= pt_s1;
			axsq_s2 <= RSQ_W'(ax_w) * RSQ_W'(ax_w);
			aysq_s2 <= RSQ_W'(ay_w) * RSQ_W'(ay_w);
			pt_s3   <= pt_s2;
			rsq_s3  <= axsq_s2 + aysq_s2;
		end
	end

	// ------------------------------------------------------------------
	// Row of root cells: r = floor(sqrt(x^2 + y^2)), one bit per cell.
	// ------------------------------------------------------------------
	logic              sr_v    [0:ROOT_W];
	logic [RSQ_W-1:0]  sr_rem  [0:ROOT_W];
	logic [ROOT_W-1:0] sr_root [0:ROOT_W];
	logic [PT_W-1:0]   sr_side [0:ROOT_W];

	assign sr_v[0]    = v_s3;
	assign sr_rem[0]  = rsq_s3;
	assign sr_root[0] = '0;
	assign sr_side[0] = pt_s3;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_root_r
		asd_sqrt_cell #(
			.VW(RSQ_W), .RW(ROOT_W), .BIT(ROOT_W - 1 - i), .SW(PT_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(sr_v[i]), .rem_i(sr_rem[i]), .root_i(sr_root[i]),
			.side_i(sr_side[i]),
			.valid_o(sr_v[i+1]), .rem_o(sr_rem[i+1]), .root_o(sr_root[i+1]),
			.side_o(sr_side[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Stages 36 to 41: projection onto the segment and the numerators of
	// the interpolation quotients.
	// ------------------------------------------------------------------
	logic                      v_s36, v_s37, v_s38, v_s39, v_s40, v_s41;
	logic        [PT_W-1:0]    pt_s36, pt_s37, pt_s38, pt_s39, pt_s40, pt_s41;
	logic        [ROOT_W-1:0]  r_s36, r_s37, r_s38, r_s39, r_s40, r_s41;
	logic signed [32:0]        a_s36, b_s36;
	logic signed [64:0]        pa_s37;
	logic signed [65:0]        pb_s37;
	logic signed [66:0]        dot_s38;
	logic        [LEN_W-1:0]   dotu_s39;
	region_t                   region_s39, region_s40, region_s41;
	logic                      degen_s39, degen_s40, degen_s41;
	logic        [53:0]        pr0_s40, pr1_s40, pr2_s40;
	logic        [54:0]        pz0_s40, pz1_s40, pz2_s40;
	logic        [DIV_N_W-1:0] nr_s41, nz_s41;
	logic signed [31:0]        z_w36;
	logic                      nonpos_w, beyond_w;
	region_t                   region_w;

	assign z_w36    = $signed(sr_side[ROOT_W][95:64]);
	assign nonpos_w = dot_s38[66] || (dot_s38 == '0);
	assign beyond_w = dot_s38[LEN_W-1:0] >= len2_q;

	// A zero-length segment is measured against its start point.
	always_comb begin
		if (degen_q || nonpos_w) begin
			region_w = REGION_START;
		end else if (beyond_w) begin
			region_w = REGION_END;
		end else begin
			region_w = REGION_INNER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
			v_s40 <= 1'b0;
			v_s41 <= 1'b0;
		end else if (adv) begin
			v_s36 <= sr_v[ROOT_W];
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
			v_s40 <= v_s39;
			v_s41 <= v_s40;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s36 <= sr_side[ROOT_W];
			r_s36  <= sr_root[ROOT_W];
			a_s36  <= $signed({1'b0, sr_root[ROOT_W]}) - $signed({2'b00, start_radius_q});
			b_s36  <= 33'(z_w36) - 33'(start_height_q);

			pt_s37 <= pt_s36;
			r_s37  <= r_s36;
			pa_s37 <= a_s36 * dr_q;
			pb_s37 <= b_s36 * dz_q;

			pt_s38  <= pt_s37;
			r_s38   <= r_s37;
			dot_s38 <= 67'(pa_s37) + 67'(pb_s37);

			pt_s39     <= pt_s38;
			r_s39      <= r_s38;
			dotu_s39   <= dot_s38[LEN_W-1:0];
			region_s39 <= region_w;
			degen_s39  <= degen_q;

			// The numerator is below 2^66 here; three narrow products each.
			pt_s40     <= pt_s39;
			r_s40      <= r_s39;
			region_s40 <= region_s39;
			degen_s40  <= degen_s39;
			pr0_s40    <= 54'(dotu_s39[CHUNK_W-1:0]) * 54'(mag_dr_q);
			pr1_s40    <= 54'(dotu_s39[2*CHUNK_W-1:CHUNK_W]) * 54'(mag_dr_q);
			pr2_s40    <= 54'(dotu_s39[3*CHUNK_W-1:2*CHUNK_W]) * 54'(mag_dr_q);
			pz0_s40    <= 55'(dotu_s39[CHUNK_W-1:0]) * 55'(mag_dz_q);
			pz1_s40    <= 55'(dotu_s39[2*CHUNK_W-1:CHUNK_W]) * 55'(mag_dz_q);
			pz2_s40    <= 55'(dotu_s39[3*CHUNK_W-1:2*CHUNK_W]) * 55'(mag_dz_q);

			// Rounded quotient: (2*p + L) / (2*L), ties away from zero.
			pt_s41     <= pt_s40;
			r_s41      <= r_s40;
			region_s41 <= region_s40;
			degen_s41  <= degen_s40;
			nr_s41 <= ((DIV_N_W'(pr0_s40) + (DIV_N_W'(pr1_s40) << CHUNK_W)
				+ (DIV_N_W'(pr2_s40) << (2 * CHUNK_W))) << 1) + DIV_N_W'(len2_q);
			nz_s41 <= ((DIV_N_W'(pz0_s40) + (DIV_N_W'(pz1_s40) << CHUNK_W)
				+ (DIV_N_W'(pz2_s40) << (2 * CHUNK_W))) << 1) + DIV_N_W'(len2_q);
		end
	end

	// ------------------------------------------------------------------
	// Two divider rows for the radial and axial interpolation offsets.
	// ------------------------------------------------------------------
	logic                dr_v    [0:DIV_Q_W];
	logic [DIV_N_W-1:0]  dr_rem  [0:DIV_Q_W];
	logic [DIV_D_W-1:0]  dr_den  [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]  dr_quo  [0:DIV_Q_W];
	logic [DIVR_S_W-1:0] dr_side [0:DIV_Q_W];
	logic                dz_v    [0:DIV_Q_W];
	logic [DIV_N_W-1:0]  dz_rem  [0:DIV_Q_W];
	logic [DIV_D_W-1:0]  dz_den  [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]  dz_quo  [0:DIV_Q_W];
	logic [2:0]          dz_side [0:DIV_Q_W];

	assign dr_v[0]    = v_s41;
	assign dr_rem[0]  = nr_s41;
	assign dr_den[0]  = den2_q;
	assign dr_quo[0]  = '0;
	assign dr_side[0] = {pt_s41, r_s41};
	assign dz_v[0]    = v_s41;
	assign dz_rem[0]  = nz_s41;
	assign dz_den[0]  = den2_q;
	assign dz_quo[0]  = '0;
	assign dz_side[0] = {region_s41, degen_s41};

	for (genvar i = 0; i < DIV_Q_W; i++) begin : g_div_interp
		asd_div_cell #(
			.NW(DIV_N_W), .DW(DIV_D_W), .QW(DIV_Q_W), .BIT(DIV_Q_W - 1 - i),
			.SW(DIVR_S_W)
		) u_rad (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(dr_v[i]), .rem_i(dr_rem[i]), .den_i(dr_den[i]),
			.quo_i(dr_quo[i]), .side_i(dr_side[i]),
			.valid_o(dr_v[i+1]), .rem_o(dr_rem[i+1]), .den_o(dr_den[i+1]),
			.quo_o(dr_quo[i+1]), .side_o(dr_side[i+1])
		);
		asd_div_cell #(
			.NW(DIV_N_W), .DW(DIV_D_W), .QW(DIV_Q_W), .BIT(DIV_Q_W - 1 - i),
			.SW(3)
		) u_ax (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(dz_v[i]), .rem_i(dz_rem[i]), .den_i(dz_den[i]),
			.quo_i(dz_quo[i]), .side_i(dz_side[i]),
			.valid_o(dz_v[i+1]), .rem_o(dz_rem[i+1]), .den_o(dz_den[i+1]),
			.quo_o(dz_quo[i+1]), .side_o(dz_side[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Stages 76 to 79: nearest (r,z) point, rotation numerators and the
	// squared distance.
	// ------------------------------------------------------------------
	logic                      v_s76, v_s77, v_s78, v_s79;
	logic        [PT_W-1:0]    pt_s76;
	logic        [ROOT_W-1:0]  r_s76, r_s77;
	logic        [RAD_W-1:0]   rn_s76, rn_s77, rn_s78;
	logic signed [COORD_W-1:0] zn_s76, zn_s77, zn_s78;
	region_t                   region_s76, region_s77, region_s78;
	logic                      degen_s76, degen_s77, degen_s78;
	logic        [62:0]        prx_s77, pry_s77;
	logic signed [32:0]        er_s77, ez_s77;
	logic                      xs_s77, ys_s77, rzero_s77;
	logic                      xs_s78, ys_s78, rzero_s78, ys_s79;
	logic        [65:0]        ersq_s78, ezsq_s78;
	logic        [ROT_N_W-1:0] nx_s78, ny_s78;
	logic        [ROT_D_W-1:0] den_s78;
	logic        [DSQ_W-1:0]   dsq_s79;
	logic signed [34:0]        rn_w, zn_w;
	logic        [RAD_W-1:0]   rn_sel;
	logic signed [COORD_W-1:0] zn_sel;
	logic        [31:0]        mx_w, my_w;
	region_t                   region_w76;

	assign region_w76 = region_t'(dz_side[DIV_Q_W][2:1]);
	assign rn_w = $signed({4'b0000, start_radius_q}) + (dr_q[31]
		? -$signed({1'b0, dr_quo[DIV_Q_W]}) : $signed({1'b0, dr_quo[DIV_Q_W]}));
	assign zn_w = 35'(start_height_q) + (dz_q[32]
		? -$signed({1'b0, dz_quo[DIV_Q_W]}) : $signed({1'b0, dz_quo[DIV_Q_W]}));

	always_comb begin
		case (region_w76)
			REGION_START: begin
				rn_sel = start_radius_q;
				zn_sel = start_height_q;
			end
			REGION_END: begin
				rn_sel = end_radius_q;
				zn_sel = end_height_q;
			end
			default: begin
				rn_sel = rn_w[RAD_W-1:0];
				zn_sel = zn_w[COORD_W-1:0];
			end
		endcase
	end

	assign mx_w = pt_s76[31] ? (32'd0 - pt_s76[31:0]) : pt_s76[31:0];
	assign my_w = pt_s76[63] ? (32'd0 - pt_s76[63:32]) : pt_s76[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s76 <= 1'b0;
			v_s77 <= 1'b0;
			v_s78 <= 1'b0;
			v_s79 <= 1'b0;
		end else if (adv) begin
			v_s76 <= dr_v[DIV_Q_W] && dz_v[DIV_Q_W];
			v_s77 <= v_s76;
			v_s78 <= v_s77;
			v_s79 <= v_s78;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s76     <= dr_side[DIV_Q_W][DIVR_S_W-1:ROOT_W];
			r_s76      <= dr_side[DIV_Q_W][ROOT_W-1:0];
			rn_s76     <= rn_sel;
			zn_s76     <= zn_sel;
			region_s76 <= region_w76;
			degen_s76  <= dz_side[DIV_Q_W][0];

			r_s77      <= r_s76;
			rn_s77     <= rn_s76;
			zn_s77     <= zn_s76;
			region_s77 <= region_s76;
			degen_s77  <= degen_s76;
			prx_s77    <= 63'(rn_s76) * 63'(mx_w);
			pry_s77    <= 63'(rn_s76) * 63'(my_w);
			er_s77     <= $signed({1'b0, r_s76}) - $signed({2'b00, rn_s76});
			ez_s77     <= 33'($signed(pt_s76[95:64])) - 33'(zn_s76);
			xs_s77     <= pt_s76[31];
			ys_s77     <= pt_s76[63];
			rzero_s77  <= r_s76 == '0;

			// Rotation back to the azimuth: round(rn * c / r).
			rn_s78     <= rn_s77;
			zn_s78     <= zn_s77;
			region_s78 <= region_s77;
			degen_s78  <= degen_s77;
			xs_s78     <= xs_s77;
			ys_s78     <= ys_s77;
			rzero_s78  <= rzero_s77;
			ersq_s78   <= er_s77 * er_s77;
			ezsq_s78   <= ez_s77 * ez_s77;
			nx_s78     <= {prx_s77, 1'b0} + ROT_N_W'(r_s77);
			ny_s78     <= {pry_s77, 1'b0} + ROT_N_W'(r_s77);
			// On the axis the quotient is discarded; keep the divisor nonzero.
			den_s78    <= rzero_s77 ? ROT_D_W'(2) : {r_s77, 1'b0};

			ys_s79  <= ys_s78;
			dsq_s79 <= DSQ_W'(ersq_s78) + DSQ_W'(ezsq_s78);
		end
	end

	// ------------------------------------------------------------------
	// Rotation divider rows and the distance root row. The rotation rows
	// are one cell longer so that all three rows finish together.
	// ------------------------------------------------------------------
	logic                rx_v    [0:ROT_Q_W];
	logic [ROT_N_W-1:0]  rx_rem  [0:ROT_Q_W];
	logic [ROT_D_W-1:0]  rx_den  [0:ROT_Q_W];
	logic [ROT_Q_W-1:0]  rx_quo  [0:ROT_Q_W];
	logic [ROTX_S_W-1:0] rx_side [0:ROT_Q_W];
	logic                ry_v    [0:ROT_Q_W];
	logic [ROT_N_W-1:0]  ry_rem  [0:ROT_Q_W];
	logic [ROT_D_W-1:0]  ry_den  [0:ROT_Q_W];
	logic [ROT_Q_W-1:0]  ry_quo  [0:ROT_Q_W];
	logic [REGION_W-1:0] ry_side [0:ROT_Q_W];
	logic                sd_v    [0:DROOT_W];
	logic [DSQ_W-1:0]    sd_rem  [0:DROOT_W];
	logic [DROOT_W-1:0]  sd_root [0:DROOT_W];
	logic                sd_side [0:DROOT_W];

	assign rx_v[0]    = v_s78;
	assign rx_rem[0]  = nx_s78;
	assign rx_den[0]  = den_s78;
	assign rx_quo[0]  = '0;
	assign rx_side[0] = {xs_s78, rzero_s78, rn_s78, zn_s78, degen_s78};
	assign ry_v[0]    = v_s78;
	assign ry_rem[0]  = ny_s78;
	assign ry_den[0]  = den_s78;
	assign ry_quo[0]  = '0;
	assign ry_side[0] = region_s78;
	assign sd_v[0]    = v_s79;
	assign sd_rem[0]  = dsq_s79;
	assign sd_root[0] = '0;
	assign sd_side[0] = ys_s79;

	for (genvar i = 0; i < ROT_Q_W; i++) begin : g_div_rot
		asd_div_cell #(
			.NW(ROT_N_W), .DW(ROT_D_W), .QW(ROT_Q_W), .BIT(ROT_Q_W - 1 - i),
			.SW(ROTX_S_W)
		) u_x (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(rx_v[i]), .rem_i(rx_rem[i]), .den_i(rx_den[i]),
			.quo_i(rx_quo[i]), .side_i(rx_side[i]),
			.valid_o(rx_v[i+1]), .rem_o(rx_rem[i+1]), .den_o(rx_den[i+1]),
			.quo_o(rx_quo[i+1]), .side_o(rx_side[i+1])
		);
		asd_div_cell #(
			.NW(ROT_N_W), .DW(ROT_D_W), .QW(ROT_Q_W), .BIT(ROT_Q_W - 1 - i),
			.SW(REGION_W)
		) u_y (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(ry_v[i]), .rem_i(ry_rem[i]), .den_i(ry_den[i]),
			.quo_i(ry_quo[i]), .side_i(ry_side[i]),
			.valid_o(ry_v[i+1]), .rem_o(ry_rem[i+1]), .den_o(ry_den[i+1]),
			.quo_o(ry_quo[i+1]), .side_o(ry_side[i+1])
		);
	end

	for (genvar i = 0; i < DROOT_W; i++) begin : g_root_d
		asd_sqrt_cell #(
			.VW(DSQ_W), .RW(DROOT_W), .BIT(DROOT_W - 1 - i), .SW(1)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(sd_v[i]), .rem_i(sd_rem[i]), .root_i(sd_root[i]),
			.side_i(sd_side[i]),
			.valid_o(sd_v[i+1]), .rem_o(sd_rem[i+1]), .root_o(sd_root[i+1]),
			.side_o(sd_side[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Saturation and the output register.
	// ------------------------------------------------------------------
	function automatic logic [COORD_W-1:0] sat_coord(input logic [ROT_Q_W-1:0] q,
		input logic neg);
		logic [COORD_W-1:0] v;
		if (q > ROT_Q_W'(32'h7FFF_FFFF)) begin
			v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			v = neg ? (32'd0 - q[COORD_W-1:0]) : q[COORD_W-1:0];
		end
		return v;
	endfunction

	logic [RAD_W-1:0]          rn_f;
	logic [COORD_W-1:0]        zn_f;
	logic                      xs_f, rzero_f, degen_f;
	logic [RAD_W-1:0]          dist_w;
	logic [COORD_W-1:0]        nx_w, ny_w;
	logic [RAD_W-1:0]          dist_q;
	logic [COORD_W-1:0]        nx_q, ny_q, nz_q;
	logic [REGION_W-1:0]       region_q;
	logic                      degen_out_q;

	assign last_valid = rx_v[ROT_Q_W] && ry_v[ROT_Q_W] && sd_v[DROOT_W];
	assign {xs_f, rzero_f, rn_f, zn_f, degen_f} = rx_side[ROT_Q_W];

	assign dist_w = (sd_root[DROOT_W] > DROOT_W'(31'h7FFF_FFFF))
		? 31'h7FFF_FFFF : sd_root[DROOT_W][RAD_W-1:0];
	// A point on the axis takes cos = 1 and sin = 0.
	assign nx_w = rzero_f ? {1'b0, rn_f} : sat_coord(rx_quo[ROT_Q_W], xs_f);
	assign ny_w = rzero_f ? '0 : sat_coord(ry_quo[ROT_Q_W], sd_side[DROOT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			dist_q      <= dist_w;
			nx_q        <= nx_w;
			ny_q        <= ny_w;
			nz_q        <= zn_f;
			region_q    <= ry_side[ROT_Q_W];
			degen_out_q <= degen_f;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, nz_q, ny_q, nx_q, dist_q};
	assign m_axis_tuser  = {degen_out_q, region_q};

endmodule
`default_nettype wire

// ===== design/asd_sqrt_cell.sv =====
// One bit step of a pipelined integer square root (remainder and partial root).
// Standalone; instantiated in rows by the top level.
`default_nettype none
module asd_sqrt_cell #(
	parameter int VW  = 64,
	parameter int RW  = 32,
	parameter int BIT = 0,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [VW-1:0] rem_i,
	input  logic [RW-1:0] root_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [VW-1:0] rem_o,
	output logic [RW-1:0] root_o,
	output logic [SW-1:0] side_o
);
	localparam int CW = 2 * RW + 1;

	logic [CW-1:0] rem_w;
	logic [CW-1:0] trial;
	logic          take;

	// Setting this bit grows the square by root*2^(BIT+1) + 2^(2*BIT).
	assign rem_w = CW'(rem_i);
	assign trial = (CW'(root_i) << (BIT + 1)) | (CW'(1) << (2 * BIT));
	assign take  = rem_w >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= take ? VW'(rem_w - trial) : rem_i;
			root_o <= take ? (root_i | (RW'(1) << BIT)) : root_i;
			side_o <= side_i;
		end
	end

endmodule
`default_nettype wire

// ===== design/asd_div_cell.sv =====
// One quotient bit step of a pipelined restoring divider.
// Standalone; instantiated in rows by the top level.
`default_nettype none
module asd_div_cell #(
	parameter int NW  = 64,
	parameter int DW  = 32,
	parameter int QW  = 32,
	parameter int BIT = 0,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [NW-1:0] rem_i,
	input  logic [DW-1:0] den_i,
	input  logic [QW-1:0] quo_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [NW-1:0] rem_o,
	output logic [DW-1:0] den_o,
	output logic [QW-1:0] quo_o,
	output logic [SW-1:0] side_o
);
	localparam int CW = ((NW > DW + BIT) ? NW : DW + BIT) + 1;

	logic [CW-1:0] rem_w;
	logic [CW-1:0] trial;
	logic          take;

	assign rem_w = CW'(rem_i);
	assign trial = CW'(den_i) << BIT;
	assign take  = rem_w >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= take ? NW'(rem_w - trial) : rem_i;
			den_o  <= den_i;
			quo_o  <= take ? (quo_i | (QW'(1) << BIT)) : quo_i;
			side_o <= side_i;
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_axisymmetric_segment_distance_unit.sv =====
// Self-checking testbench of axisymmetric_segment_distance_unit.
// It streams query points through the block under random back-pressure and compares
// every result with a bit-exact predictor. Depends on asd_pkg and the RTL of the unit.
`timescale 1ns / 100ps

typedef logic signed [127:0] s128_t;
typedef logic [127:0] u128_t;

typedef struct {
	logic [asd_pkg::OUT_DATA_W-1:0] data;
	logic [asd_pkg::OUT_USER_W-1:0] user;
} surf_result_t;

class surface_scoreboard;
	// Copy of the segment registers.
	longint seg_r0, seg_z0, seg_r1, seg_z1;
	surf_result_t awaited[$];
	int errors;

	function new();
		seg_r0 = 0;
		seg_z0 = 0;
		seg_r1 = 65536;
		seg_z1 = 65536;
		errors = 0;
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	function void set_reg(logic [asd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			asd_pkg::REG_START_RADIUS: seg_r0 = longint'(val[30:0]);
			asd_pkg::REG_START_HEIGHT: seg_z0 = longint'($signed(val));
			asd_pkg::REG_END_RADIUS:   seg_r1 = longint'(val[30:0]);
			asd_pkg::REG_END_HEIGHT:   seg_z1 = longint'($signed(val));
			default: ;
		endcase
	endfunction

	// Integer square root, floor, for arguments below 2^126.
	function logic [63:0] floor_root(u128_t v);
		logic [63:0] res, cand;
		res = 0;
		for (int b = 62; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (u128_t'(cand) * u128_t'(cand) <= v) res = cand;
		end
		return res;
	endfunction

	// Offset along one axis: round(delta * dot / len2), ties away from zero.
	function longint interp(s128_t dot, s128_t len2, longint delta);
		u128_t p, q;
		longint mag;
		mag = (delta < 0) ? -delta : delta;
		p = u128_t'(dot) * u128_t'(mag);
		q = (2 * p + u128_t'(len2)) / (2 * u128_t'(len2));
		return (delta < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// Scales a nearest radius back onto one Cartesian axis, saturated.
	function logic [31:0] rotate(longint rn, longint c, longint r);
		u128_t p, q;
		longint mag, v;
		mag = (c < 0) ? -c : c;
		p = u128_t'(rn) * u128_t'(mag);
		q = (2 * p + u128_t'(r)) / (2 * u128_t'(r));
		if (q > 128'h7FFF_FFFF) q = (c < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
		v = (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		return v[31:0];
	endfunction

	// Works out the result of one accepted point and queues it.
	function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		longint x, y, z, ri, dr, dz, rn, zn, ea, eb;
		s128_t len2, dot;
		logic [63:0] dist_val;
		logic [31:0] nx, ny;
		logic degen;
		asd_pkg::region_t reg_kind;
		surf_result_t res;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		ri = longint'(floor_root(u128_t'(s128_t'(x) * s128_t'(x) + s128_t'(y) * s128_t'(y))));
		dr = seg_r1 - seg_r0;
		dz = seg_z1 - seg_z0;
		len2 = s128_t'(dr) * s128_t'(dr) + s128_t'(dz) * s128_t'(dz);
		dot = s128_t'(ri - seg_r0) * s128_t'(dr) + s128_t'(z - seg_z0) * s128_t'(dz);
		degen = (dr == 0) && (dz == 0);
		// A zero-length segment falls back to the start endpoint.
		if (degen || dot <= 0) begin
			rn = seg_r0;
			zn = seg_z0;
			reg_kind = asd_pkg::REGION_START;
		end else if (dot >= len2) begin
			rn = seg_r1;
			zn = seg_z1;
			reg_kind = asd_pkg::REGION_END;
		end else begin
			rn = seg_r0 + interp(dot, len2, dr);
			zn = seg_z0 + interp(dot, len2, dz);
			reg_kind = asd_pkg::REGION_INNER;
		end
		ea = ri - rn;
		eb = z - zn;
		dist_val = floor_root(u128_t'(s128_t'(ea) * s128_t'(ea) + s128_t'(eb) * s128_t'(eb)));
		if (dist_val > 64'h7FFF_FFFF) dist_val = 64'h7FFF_FFFF;
		// A point on the axis has no azimuth and takes the x direction.
		if (ri == 0) begin
			nx = rn[31:0];
			ny = 32'd0;
		end else begin
			nx = rotate(rn, x, ri);
			ny = rotate(rn, y, ri);
		end
		res.data = {1'b0, zn[31:0], ny, nx, dist_val[30:0]};
		res.user = {degen, reg_kind};
		awaited.push_back(res);
	endfunction

	function void check_result(logic [asd_pkg::OUT_DATA_W-1:0] data,
		logic [asd_pkg::OUT_USER_W-1:0] user);
		surf_result_t want;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result data=%h user=%h", data, user);
			return;
		end
		want = awaited.pop_front();
		if (want.data[30:0] !== data[30:0] || want.data[62:31] !== data[62:31] ||
			want.data[94:63] !== data[94:63] || want.data[126:95] !== data[126:95] ||
			want.data[127] !== data[127] || want.user[1:0] !== user[1:0] ||
			want.user[2] !== user[2]) begin
			errors++;
			if (errors <= 10) begin
				$display("result error: expected dist=%h nx=%h ny=%h nz=%h pad=%b reg=%0d deg=%b",
					want.data[30:0], want.data[62:31], want.data[94:63], want.data[126:95],
					want.data[127], want.user[1:0], want.user[2]);
				$display("              actual   dist=%h nx=%h ny=%h nz=%h pad=%b reg=%0d deg=%b",
					data[30:0], data[62:31], data[94:63], data[126:95],
					data[127], user[1:0], user[2]);
			end
		end
	endfunction
endclass

module tb_axisymmetric_segment_distance_unit;
	import asd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 200;
	localparam int ITEMS_PER_PHASE = 130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	surface_scoreboard sb;
	int cycles = 0;
	int stall_left = 0;
	bit steady = 1'b0;    // when set, neither side idles

	axisymmetric_segment_distance_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 60) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls of the result stream.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			stall_left <= gap_len();
			m_axis_tready <= 1'b1;
		end
	end

	// Every accepted result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && sb != null && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// One register write; cfg_valid stays high until the caller lowers it.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_segment(logic [31:0] r0, logic [31:0] z0, logic [31:0] r1,
		logic [31:0] z1);
		write_reg(REG_START_RADIUS, r0);
		write_reg(REG_START_HEIGHT, z0);
		write_reg(REG_END_RADIUS, r1);
		write_reg(REG_END_HEIGHT, z1);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one point, with a random gap ahead of it, and notes it once transferred.
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_point(x, y, z);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Coordinates: extremes, small values near typical segments, or fully random.
	function automatic logic [31:0] rand_coord();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'd0;
				3: return 32'd1;
				default: return 32'hFFFF_FFFF;
			endcase
			1, 2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 7);
			default: return 32'($signed($urandom_range(0, 24 << 16)) - (12 << 16));
		endcase
	endfunction

	task automatic random_points(int count);
		for (int i = 0; i < count; i++) begin
			// A stretch without idling on either side now and then.
			if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			send_point(rand_coord(), rand_coord(), rand_coord());
		end
		steady = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points against the reset segment from (0,0) to (1,1).
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'd0, 32'd0, 32'h0005_0000);                // on the axis
		send_point(32'd0, 32'd0, 32'hFFFB_0000);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'd0, 32'd0);
		send_point(32'd0, 32'h8000_0000, 32'h0001_0000);
		send_point(32'h0001_0000, 32'd0, 32'd0);                // interior
		send_point(32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000);
		send_point(32'h0003_0000, 32'h0004_0000, 32'h000A_0000); // past the end
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'd1, 32'd0, 32'd0);
		send_point(32'h0000_0001, 32'h0000_0001, 32'd1);
		drain();

		// An index past the four registers must leave the segment alone.
		write_reg(8'd7, 32'h1234_5678);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_point(32'h0001_0000, 32'd0, 32'd0);
		random_points(ITEMS_PER_PHASE / 2);
		// Hold the sender until everything in flight has come out.
		drain();
		random_points(ITEMS_PER_PHASE / 2);
		drain();

		// Widest segment, from the lowest to the highest corner.
		set_segment(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		random_points(ITEMS_PER_PHASE);
		drain();

		// Zero-length segment.
		set_segment(32'h0003_0000, 32'hFFFB_0000, 32'h0003_0000, 32'hFFFB_0000);
		send_point(32'd0, 32'd0, 32'd0);
		random_points(ITEMS_PER_PHASE);
		drain();

		// Reversed extremes.
		set_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000);
		random_points(ITEMS_PER_PHASE);
		drain();

		// Cylinder wall of radius 2.
		set_segment(32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0001_0000);
		random_points(ITEMS_PER_PHASE);
		drain();

		// Random small segments, then random full-range ones.
		for (int k = 0; k < 3; k++) begin
			set_segment($urandom_range(0, 10 << 16), rand_coord(),
				$urandom_range(0, 10 << 16), rand_coord());
			random_points(ITEMS_PER_PHASE / 3);
			drain();
		end
		for (int k = 0; k < 3; k++) begin
			set_segment($urandom_range(0, 32'h7FFF_FFFF), $urandom,
				$urandom_range(0, 32'h7FFF_FFFF), $urandom);
			random_points(ITEMS_PER_PHASE / 3);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== files.f =====
design/asd_pkg.sv
design/asd_sqrt_cell.sv
design/asd_div_cell.sv
design/axisymmetric_segment_distance_unit.sv
sim/tb_axisymmetric_segment_distance_unit.sv
